>>> rtl/core/assert_macros.svh
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/core/skf_pkg.sv
`default_nettype none
package skf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int GAIN_W    = FRAC_W + 1;           // Q1.16, 0..1.0
  localparam int OPND_W    = DATA_W + 2;           // divisor / multiplicand
  localparam int ACC_W     = OPND_W + GAIN_W;      // product accumulator
  localparam int CFG_IDX_W = 1;

  localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(1) << FRAC_W;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'b1;

  localparam logic [DATA_W-1:0] PROCESS_NOISE_RST     = 32'd1310720;
  localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RST = 32'd13107200;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DATA_W-1:0]   filtered_t;

  typedef struct packed {
    logic start;
    logic op_div;
  } skf_alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } skf_alu_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/skf_if.sv
`default_nettype none
interface skf_in_if import skf_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface skf_out_if import skf_pkg::*; ();
  logic      valid;
  logic      ready;
  filtered_t filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface
`default_nettype wire

>>> rtl/core/skf_alu.sv
`default_nettype none
// Shared iterative unit: restoring radix-2 divide or MSB-first shift-add
// multiply, one bit per cycle over GAIN_W steps, through one adder.
module skf_alu import skf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  skf_alu_ctl_t        ctl,
  input  logic [OPND_W-1:0]   opnd_x,    // dividend
  input  logic [OPND_W-1:0]   opnd_y,    // divisor or signed multiplicand
  input  logic [GAIN_W-1:0]   opnd_m,    // unsigned multiplier
  output skf_alu_sts_t        sts,
  output logic [ACC_W-1:0]    product,
  output logic [GAIN_W-1:0]   quotient
);

  localparam int STEPS = GAIN_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam int EXT_W = ACC_W - OPND_W;

  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [OPND_W-1:0] mcand_r, mcand_nxt;
  logic [GAIN_W-1:0] mplier_r, mplier_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              op_div_r, op_div_nxt;

  logic [ACC_W-1:0]  add_a, add_b, sum;
  logic              cin, ge, last;
  logic [OPND_W-1:0] rem;

  always_comb begin
    if (op_div_r) begin
      add_a = {{EXT_W{1'b0}}, acc_r[OPND_W-1:0]};
      add_b = ~{{EXT_W{1'b0}}, mcand_r};
      cin   = 1'b1;
    end else begin
      add_a = {acc_r[ACC_W-2:0], 1'b0};
      add_b = mplier_r[GAIN_W-1] ? {{EXT_W{mcand_r[OPND_W-1]}}, mcand_r} : '0;
      cin   = 1'b0;
    end
    sum  = add_a + add_b + {{(ACC_W-1){1'b0}}, cin};
    ge   = ~sum[ACC_W-1];
    rem  = ge ? sum[OPND_W-1:0] : acc_r[OPND_W-1:0];
    last = (cnt_r == '0);
  end

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    op_div_nxt = op_div_r;
    if (ctl.start) begin
      acc_nxt    = ctl.op_div ? {{EXT_W{1'b0}}, opnd_x} : '0;
      mcand_nxt  = opnd_y;
      mplier_nxt = ctl.op_div ? '0 : opnd_m;
      cnt_nxt    = CNT_W'(STEPS - 1);
      busy_nxt   = 1'b1;
      op_div_nxt = ctl.op_div;
    end else if (busy_r) begin
      if (op_div_r) begin
        // remainder stays below the divisor, so the shift drops a zero
        acc_nxt    = {{EXT_W{1'b0}}, (last ? rem : {rem[OPND_W-2:0], 1'b0})};
        mplier_nxt = {mplier_r[GAIN_W-2:0], ge};
      end else begin
        acc_nxt    = sum;
        mplier_nxt = {mplier_r[GAIN_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
    op_div_r <= op_div_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign product  = acc_r;
  assign quotient = mplier_r;

endmodule
`default_nettype wire

>>> rtl/core/scalar_kalman_filter_core.sv
// Scalar Kalman filter core, random-walk model, Q16.16 fixed point.
// Steps: prep, divide, estimate multiply, covariance multiply, write-back; the
// divide is skipped when the gain denominator is zero. One item in flight: a new
// sample is taken only in idle, once the last result is written back; a held
// result stalls write-back. Divide and multiplies share the single div/mul unit.
// Reset: state cleared.
`default_nettype none
`include "assert_macros.svh"
module scalar_kalman_filter_core import skf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [DATA_W-1:0]     cfg_wdata,
  skf_in_if.sink                in_ch,
  skf_out_if.source             out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL_E = 3'd3;
  localparam logic [2:0] S_MUL_C = 3'd4;
  localparam logic [2:0] S_WB    = 3'd5;

  localparam int PROD_LO = FRAC_W;
  localparam int PROD_HI = FRAC_W + DATA_W - 1;

  logic [2:0]        state_r, state_nxt;
  logic [DATA_W-1:0] q_r, r_r;
  filtered_t         est_r, est_nxt;
  logic [DATA_W-1:0] cov_r, cov_nxt;
  sample_t           sample_r;
  logic [DATA_W-1:0] pred_r;
  logic [DATA_W:0]   diff_r;
  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic              out_valid_r, out_valid_nxt;
  filtered_t         out_data_r;

  // Prediction, gain denominator and innovation, formed in the prep state.
  logic [DATA_W:0]   pred_sum, den, diff;
  logic [DATA_W-1:0] pred_sat;
  logic              den_nz;

  skf_alu_ctl_t      alu_ctl;
  skf_alu_sts_t      alu_sts;
  logic [OPND_W-1:0] alu_x, alu_y;
  logic [GAIN_W-1:0] alu_m;
  logic [ACC_W-1:0]  alu_prod;
  logic [GAIN_W-1:0] alu_quot;

  logic in_xfer, out_xfer;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  always_comb begin
    pred_sum = {1'b0, cov_r} + {1'b0, q_r};
    pred_sat = pred_sum[DATA_W] ? '1 : pred_sum[DATA_W-1:0];   // saturate
    den      = {1'b0, pred_sat} + {1'b0, r_r};                 // cannot wrap
    den_nz   = |den;
    diff     = {sample_r[SAMPLE_W-1], sample_r, {FRAC_W{1'b0}}} - {est_r[DATA_W-1], est_r};
  end

  // Sequencer: prep -> divide -> estimate multiply -> covariance multiply -> write-back.
  // A zero denominator skips the divide and runs the multiplies with gain 0.
  always_comb begin
    state_nxt      = state_r;
    est_nxt        = est_r;
    cov_nxt        = cov_r;
    gain_nxt       = gain_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    alu_ctl.start  = 1'b0;
    alu_ctl.op_div = 1'b0;
    alu_x          = {2'b00, pred_sat};
    alu_y          = {{(OPND_W-DATA_W-1){diff_r[DATA_W]}}, diff_r};
    alu_m          = alu_quot;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_PREP;
      end
      S_PREP: begin
        alu_ctl.start = 1'b1;
        if (den_nz) begin
          alu_ctl.op_div = 1'b1;
          alu_y          = {1'b0, den};
          state_nxt      = S_DIV;
        end else begin
          alu_y     = {{(OPND_W-DATA_W-1){diff[DATA_W]}}, diff};
          alu_m     = '0;
          gain_nxt  = '0;
          state_nxt = S_MUL_E;
        end
      end
      S_DIV: begin
        if (alu_sts.done) begin
          gain_nxt      = alu_quot;
          alu_ctl.start = 1'b1;
          state_nxt     = S_MUL_E;
        end
      end
      S_MUL_E: begin
        if (alu_sts.done) begin
          // floor(gain * diff / 2^16); new estimate is known to fit 32 bits
          est_nxt       = est_r + filtered_t'(alu_prod[PROD_HI:PROD_LO]);
          alu_ctl.start = 1'b1;
          alu_y         = {2'b00, pred_r};
          alu_m         = ONE_Q16 - gain_r;
          state_nxt     = S_MUL_C;
        end
      end
      S_MUL_C: begin
        if (alu_sts.done) begin
          cov_nxt   = alu_prod[PROD_HI:PROD_LO];
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      q_r         <= PROCESS_NOISE_RST;
      r_r         <= MEASUREMENT_NOISE_RST;
      est_r       <= '0;
      cov_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      est_r       <= est_nxt;
      cov_r       <= cov_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_PROCESS_NOISE:     q_r <= cfg_wdata;
          REG_MEASUREMENT_NOISE: r_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    if (in_xfer) sample_r <= in_ch.sample;
    if (state_r == S_PREP) begin
      pred_r <= pred_sat;
      diff_r <= diff;
    end
    gain_r <= gain_nxt;
    if (state_r == S_WB && (!out_valid_r || out_ch.ready)) out_data_r <= est_r;
  end

  skf_alu u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (alu_ctl),
    .opnd_x   (alu_x),
    .opnd_y   (alu_y),
    .opnd_m   (alu_m),
    .sts      (alu_sts),
    .product  (alu_prod),
    .quotient (alu_quot)
  );

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = out_data_r;

  // Unit is never restarted while it still iterates.
  `ASSERT_NEVER(a_alu_start_busy, alu_ctl.start && alu_sts.busy, "alu restarted while busy")
  // Unit completions arrive only while the sequencer waits for them.
  `ASSERT_CLK(a_alu_done_wait, alu_sts.done |-> (state_r == S_DIV || state_r == S_MUL_E || state_r == S_MUL_C), "alu done outside wait state")
  // Gain never exceeds one once latched after the divide.
  `ASSERT_CLK(a_gain_range, (state_r == S_MUL_C) |-> (gain_r <= ONE_Q16), "gain above one")

endmodule
`default_nettype wire
